/* rtl/irc_pkg.sv */
// irc_pkg: shared types, codes and sizes of the inode reference count cache
// no dependencies; imported by every module of the block
`default_nettype none

package irc_pkg;

    localparam int ENTRIES = 16;
    localparam int SLOT_W  = $clog2(ENTRIES);
    localparam int REF_W   = 16;
    localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};

    // request actions
    localparam logic [1:0] ACT_GET     = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_LOCK    = 2'd2;

    // result status codes
    localparam logic [2:0] ST_HIT        = 3'd0;
    localparam logic [2:0] ST_ALLOCATED  = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_INVALID    = 3'd3;
    localparam logic [2:0] ST_NEEDS_LOAD = 3'd4;
    localparam logic [2:0] ST_LOADED     = 3'd5;
    localparam logic [2:0] ST_RELEASED   = 3'd6;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] device;
        logic [31:0] inode_number;
        logic [3:0]  entry_index;
    } t_in_item;

    typedef struct packed {
        logic [3:0]       slot;
        logic [2:0]       status;
        logic [REF_W-1:0] ref_count;
    } t_out_item;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic search;
        logic update;
    } t_cmd;

    // operation decided by the search step
    typedef enum logic [2:0] {
        K_HIT,
        K_ALLOC,
        K_FULL,
        K_INVALID,
        K_RELEASE,
        K_LOCK
    } t_kind;

    // low four bits of an entry number
    function automatic logic [3:0] to_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W+3:0] ext;
        ext = {4'd0, s};
        return ext[3:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/irc_ctrl.sv */
// irc_ctrl: sequencing state machine of the inode reference count cache
// depends on irc_pkg
`default_nettype none

module irc_ctrl (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          start,
    output logic         busy,
    output irc_pkg::t_cmd o_cmd,
    output logic         o_valid
);
    import irc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_UPDATE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_valid;

    assign busy         = (r_state == S_SEARCH);
    assign o_cmd.load   = start && !busy;
    assign o_cmd.search = (r_state == S_SEARCH);
    assign o_cmd.update = (r_state == S_UPDATE);
    assign o_valid      = r_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   n_state = start ? S_SEARCH : S_IDLE;
            S_SEARCH: n_state = S_UPDATE;
            S_UPDATE: n_state = start ? S_SEARCH : S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= o_cmd.update;
        end
    end

endmodule

`default_nettype wire

/* rtl/irc_datapath.sv */
// irc_datapath: entry table, associative search and count update
// depends on irc_pkg; driven by irc_ctrl commands
`default_nettype none

module irc_datapath (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  irc_pkg::t_cmd     i_cmd,
    input  irc_pkg::t_in_item i_item,
    output irc_pkg::t_out_item o_result
);
    import irc_pkg::*;

    // entry table
    logic [15:0]      r_dev    [ENTRIES];
    logic [31:0]      r_ino    [ENTRIES];
    logic [REF_W-1:0] r_refs   [ENTRIES];
    logic             r_loaded [ENTRIES];

    // request and search results
    t_in_item         r_req;
    t_kind            r_kind, n_kind;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [3:0]       r_oslot, n_oslot;
    t_out_item        r_out, n_out;

    // search step
    logic [SLOT_W-1:0] match_idx, free_idx, req_idx;
    logic              any_match, any_free, idx_bad;
    logic [SLOT_W+3:0] idx_ext;

    // update step
    logic [REF_W-1:0] cur_ref, wr_ref;
    logic             cur_loaded;
    logic             ref_we, loaded_we, loaded_wd, ident_we;

    assign idx_ext = {{SLOT_W{1'b0}}, r_req.entry_index};
    assign req_idx = idx_ext[SLOT_W-1:0];
    assign idx_bad = ({28'd0, r_req.entry_index} >= 32'(ENTRIES));

    // lowest live match and lowest free entry
    always_comb begin
        match_idx = '0;
        free_idx  = '0;
        any_match = 1'b0;
        any_free  = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_refs[i] != '0 && r_dev[i] == r_req.device
                    && r_ino[i] == r_req.inode_number) begin
                match_idx = SLOT_W'(i);
                any_match = 1'b1;
            end
            if (r_refs[i] == '0) begin
                free_idx = SLOT_W'(i);
                any_free = 1'b1;
            end
        end
    end

    always_comb begin
        n_kind  = K_INVALID;
        n_slot  = '0;
        n_oslot = 4'd0;
        unique case (r_req.action)
            ACT_GET: begin
                if (any_match) begin
                    n_kind  = K_HIT;
                    n_slot  = match_idx;
                    n_oslot = to_slot(match_idx);
                end else if (any_free) begin
                    n_kind  = K_ALLOC;
                    n_slot  = free_idx;
                    n_oslot = to_slot(free_idx);
                end else begin
                    n_kind = K_FULL;
                end
            end
            ACT_RELEASE, ACT_LOCK: begin
                n_oslot = r_req.entry_index;
                n_slot  = req_idx;
                if (idx_bad) begin
                    n_kind = K_INVALID;
                end else if (r_req.action == ACT_RELEASE) begin
                    n_kind = K_RELEASE;
                end else begin
                    n_kind = K_LOCK;
                end
            end
            default: begin
                n_kind = K_INVALID;
            end
        endcase
    end

    // read-modify-write of the addressed entry
    assign cur_ref    = r_refs[r_slot];
    assign cur_loaded = r_loaded[r_slot];

    always_comb begin
        wr_ref    = cur_ref;
        ref_we    = 1'b0;
        loaded_we = 1'b0;
        loaded_wd = 1'b0;
        ident_we  = 1'b0;
        n_out     = '{slot: r_oslot, status: ST_INVALID, ref_count: '0};
        unique case (r_kind)
            K_HIT: begin
                wr_ref = (cur_ref == REF_MAX) ? cur_ref : cur_ref + 1'b1;
                ref_we = 1'b1;
                n_out.status    = ST_HIT;
                n_out.ref_count = wr_ref;
            end
            K_ALLOC: begin
                wr_ref    = REF_W'(1);
                ref_we    = 1'b1;
                loaded_we = 1'b1;
                ident_we  = 1'b1;
                n_out.status    = ST_ALLOCATED;
                n_out.ref_count = wr_ref;
            end
            K_FULL: begin
                n_out.status = ST_FULL;
            end
            K_RELEASE: begin
                wr_ref = (cur_ref == '0) ? cur_ref : cur_ref - 1'b1;
                ref_we = 1'b1;
                n_out.status    = ST_RELEASED;
                n_out.ref_count = wr_ref;
            end
            K_LOCK: begin
                if (cur_ref == '0) begin
                    n_out.status = ST_INVALID;
                end else if (cur_loaded) begin
                    n_out.status    = ST_LOADED;
                    n_out.ref_count = cur_ref;
                end else begin
                    loaded_we       = 1'b1;
                    loaded_wd       = 1'b1;
                    n_out.status    = ST_NEEDS_LOAD;
                    n_out.ref_count = cur_ref;
                end
            end
            default: begin
                n_out.status = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_refs[i]   <= '0;
                r_loaded[i] <= 1'b0;
            end
        end else if (i_cmd.update) begin
            if (ref_we) begin
                r_refs[r_slot] <= wr_ref;
            end
            if (loaded_we) begin
                r_loaded[r_slot] <= loaded_wd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && ident_we) begin
            r_dev[r_slot] <= r_req.device;
            r_ino[r_slot] <= r_req.inode_number;
        end
        if (i_cmd.load) begin
            r_req <= i_item;
        end
        if (i_cmd.search) begin
            r_kind  <= n_kind;
            r_slot  <= n_slot;
            r_oslot <= n_oslot;
        end
        if (i_cmd.update) begin
            r_out <= n_out;
        end
    end

    assign o_result = r_out;

endmodule

`default_nettype wire

/* rtl/inode_refcount_cache.sv */
// inode_refcount_cache: top level of the inode reference count cache
// depends on irc_pkg, irc_ctrl and irc_datapath
`default_nettype none

// usage
// - request channel: drive i_item and raise start; the item is taken at a
//   rising edge where start is high and busy is low
// - actions: get by device and inode number, release an entry, lock an entry
// - result channel: o_result holds slot, status and count, and o_valid marks
//   it for exactly one cycle; there is no back-pressure, the receiver must
//   take it in that cycle
// - steps: after the accepting edge, an associative search over all entries,
//   then a read-modify-write on the chosen entry; o_result and o_valid are
//   registered at the end of the update
// - overlap: busy is high only during the search cycle, so the next item is
//   taken while the count update of the previous one is written
// - the search compares every live entry in parallel and picks the lowest
//   match or the lowest free entry, so the table size sets its depth
// - reset (synchronous, active low) clears every count and loaded mark at
//   once; device and inode fields are left as they are and are only looked
//   at for entries with a nonzero count
// - no clearing pass: the block can take an item right after reset is released

module inode_refcount_cache (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  irc_pkg::t_in_item  i_item,
    output logic               o_valid,
    output irc_pkg::t_out_item o_result
);
    import irc_pkg::*;

    t_cmd cmd;

    // sequencing: idle, search, update
    irc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd),
        .o_valid (o_valid)
    );

    // entry table, compare and count arithmetic
    irc_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    // an accepted item always enters search in the cycle after it is taken
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not enter search");

    // search is never held; busy is low in the cycle after it is high
    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("search held for more than one cycle");

    // a result follows every search, after the update step
    a_result_after_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> ##1 o_valid)
        else $error("result missing after search");

    // no result unless a search came before its update step
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy, 2))
        else $error("result without a search");

    // results never come back to back
    a_valid_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two results in consecutive cycles");
`endif

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// tb_top: self-checking testbench for the inode reference count cache
// depends on irc_pkg and inode_refcount_cache; directed table, repeated hits,
// table fill, then random request phases, every result checked in order
`timescale 1ns / 100ps

module tb_top;
    import irc_pkg::*;

    // action code the block does not define, must come back as invalid
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int KEYS           = 24;     // small key pool so gets hit and fill the table
    localparam int PHASE_ITEMS    = 160;
    localparam int MIX_SPAN       = 40;     // items per fill-biased or drain-biased stretch
    localparam int HIT_GETS       = 24;     // back-to-back gets on one key
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        t_in_item  req;
        bit        typed;
        t_out_item res;
    } t_dir_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_item  req_item = '0;
    logic      o_valid;
    t_out_item o_result;

    // shadow copy of the entry table
    logic [15:0]      shadow_dev    [ENTRIES];
    logic [31:0]      shadow_ino    [ENTRIES];
    logic [REF_W-1:0] shadow_refs   [ENTRIES];
    bit               shadow_loaded [ENTRIES];

    t_out_item pending_results [$];
    t_dir_row  dir_rows [$];

    // result typed into the directed table for the item being driven
    bit        typed_valid = 1'b0;
    t_out_item typed_result = '0;

    logic [15:0] key_dev [KEYS];
    logic [31:0] key_ino [KEYS];

    int mismatch_count = 0;
    int idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    inode_refcount_cache dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (req_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // expected result of one request, updating the shadow table
    function automatic t_out_item apply_request(input t_in_item it);
        t_out_item r;
        int        free_idx;
        int        i;
        int        idx;
        r = '{slot: 4'd0, status: ST_INVALID, ref_count: '0};
        free_idx = -1;
        idx = int'(it.entry_index);
        if (it.action == ACT_GET) begin
            for (i = 0; i < ENTRIES; i++) begin
                if (shadow_refs[i] != '0 && shadow_dev[i] == it.device &&
                    shadow_ino[i] == it.inode_number) begin
                    // count sticks at its maximum
                    if (shadow_refs[i] != REF_MAX)
                        shadow_refs[i] = shadow_refs[i] + 1'b1;
                    r.slot = 4'(i);
                    r.status = ST_HIT;
                    r.ref_count = shadow_refs[i];
                    return r;
                end
                if (free_idx < 0 && shadow_refs[i] == '0)
                    free_idx = i;
            end
            if (free_idx < 0) begin
                r.status = ST_FULL;
                return r;
            end
            shadow_dev[free_idx] = it.device;
            shadow_ino[free_idx] = it.inode_number;
            shadow_refs[free_idx] = 1;
            shadow_loaded[free_idx] = 1'b0;
            r.slot = 4'(free_idx);
            r.status = ST_ALLOCATED;
            r.ref_count = 1;
            return r;
        end
        if (it.action != ACT_RELEASE && it.action != ACT_LOCK)
            return r;
        r.slot = it.entry_index;
        if (idx >= ENTRIES)
            return r;
        if (it.action == ACT_RELEASE) begin
            // never below zero
            if (shadow_refs[idx] != '0)
                shadow_refs[idx] = shadow_refs[idx] - 1'b1;
            r.status = ST_RELEASED;
            r.ref_count = shadow_refs[idx];
            return r;
        end
        if (shadow_refs[idx] == '0)
            return r;
        r.ref_count = shadow_refs[idx];
        if (shadow_loaded[idx]) begin
            r.status = ST_LOADED;
        end else begin
            shadow_loaded[idx] = 1'b1;
            r.status = ST_NEEDS_LOAD;
        end
        return r;
    endfunction

    function automatic t_in_item make_req(input logic [1:0] act, input logic [15:0] dev,
                                          input logic [31:0] ino, input logic [3:0] idx);
        t_in_item it;
        it.action = act;
        it.device = dev;
        it.inode_number = ino;
        it.entry_index = idx;
        return it;
    endfunction

    // row checked against the shadow table
    function automatic void add_row(input logic [1:0] act, input logic [15:0] dev,
                                    input logic [31:0] ino, input logic [3:0] idx);
        t_dir_row row;
        row.req = make_req(act, dev, ino, idx);
        row.typed = 1'b0;
        row.res = '0;
        dir_rows.push_back(row);
    endfunction

    // row whose result is plain from the request alone
    function automatic void add_checked_row(input logic [1:0] act, input logic [15:0] dev,
                                            input logic [31:0] ino, input logic [3:0] idx,
                                            input logic [3:0] slot, input logic [2:0] status,
                                            input logic [REF_W-1:0] cnt);
        t_dir_row row;
        row.req = make_req(act, dev, ino, idx);
        row.typed = 1'b1;
        row.res = '{slot: slot, status: status, ref_count: cnt};
        dir_rows.push_back(row);
    endfunction

    // gets mostly on pooled keys; fill stretches push the table toward full,
    // drain stretches release entries again; a few requests carry random keys
    function automatic t_in_item random_request(input bit fill_bias);
        t_in_item it;
        int       roll;
        int       k;
        it = make_req(ACT_GET, 16'($urandom), $urandom, 4'($urandom));
        roll = $urandom_range(99);
        if (roll < (fill_bias ? 70 : 35)) begin
            if ($urandom_range(9) != 0) begin
                k = $urandom_range(KEYS - 1);
                it.device = key_dev[k];
                it.inode_number = key_ino[k];
            end
        end else if (roll < (fill_bias ? 85 : 75)) begin
            it.action = ACT_RELEASE;
        end else if (roll < 96) begin
            it.action = ACT_LOCK;
        end else begin
            it.action = ACT_UNUSED;
        end
        return it;
    endfunction

    function automatic void flag_mismatch(input string what, input t_out_item want,
                                          input t_out_item got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s want slot %0d status %0d count %0d, %s",
                     $realtime, what, want.slot, want.status, want.ref_count,
                     $sformatf("got slot %0d status %0d count %0d",
                               got.slot, got.status, got.ref_count));
    endfunction

    // one item: optional idle cycles, then hold start until the block takes it
    task automatic drive_item(input t_in_item it, input int idle_pct, input bit has_typed,
                              input t_out_item typed);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        typed_valid = has_typed;
        typed_result = typed;
        start <= 1'b1;
        req_item <= it;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
    endtask

    // sender stops until every outstanding result is back
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // result checker and request predictor, both on the rising edge
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("unexpected result,", '0, o_result);
                end else begin
                    want = pending_results.pop_front();
                    if (o_result.slot !== want.slot)
                        flag_mismatch("slot,", want, o_result);
                    else if (o_result.status !== want.status)
                        flag_mismatch("status,", want, o_result);
                    else if (o_result.ref_count !== want.ref_count)
                        flag_mismatch("ref_count,", want, o_result);
                end
            end
            if (start && !busy) begin
                want = apply_request(req_item);
                pending_results.push_back(typed_valid ? typed_result : want);
            end
        end
    end

    // watchdog: cycles with neither an item taken nor a result delivered
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int        phase_pct [4];
        int        p;
        int        n;
        t_out_item none;
        none = '0;
        phase_pct = '{0, 81, 13, 0};
        for (n = 0; n < ENTRIES; n++) begin
            shadow_dev[n] = '0;
            shadow_ino[n] = '0;
            shadow_refs[n] = '0;
            shadow_loaded[n] = 1'b0;
        end
        // key pool keeps the all-zero and all-one keys
        key_dev[0] = 16'h0000;
        key_ino[0] = 32'h0000_0000;
        key_dev[1] = 16'hffff;
        key_ino[1] = 32'hffff_ffff;
        for (n = 2; n < KEYS; n++) begin
            key_dev[n] = 16'($urandom);
            key_ino[n] = $urandom;
        end

        // directed table
        // lock and release of free entries right after reset, undefined action
        add_checked_row(ACT_LOCK, 16'h0000, 32'h0000_0000, 4'd0, 4'd0, ST_INVALID, 16'd0);
        add_checked_row(ACT_RELEASE, 16'hffff, 32'hffff_ffff, 4'd15, 4'd15, ST_RELEASED, 16'd0);
        add_checked_row(ACT_UNUSED, 16'hffff, 32'hffff_ffff, 4'd15, 4'd0, ST_INVALID, 16'd0);
        // extreme keys allocate the two lowest entries
        add_checked_row(ACT_GET, 16'h0000, 32'h0000_0000, 4'd0, 4'd0, ST_ALLOCATED, 16'd1);
        add_checked_row(ACT_GET, 16'hffff, 32'hffff_ffff, 4'd15, 4'd1, ST_ALLOCATED, 16'd1);
        add_row(ACT_GET, 16'h0000, 32'h0000_0000, 4'd15);
        // device matches but inode does not, and the reverse
        add_row(ACT_GET, 16'hffff, 32'h0000_0000, 4'd0);
        add_row(ACT_GET, 16'h0000, 32'hffff_ffff, 4'd0);
        // first lock needs a load, second finds it loaded
        add_row(ACT_LOCK, 16'hffff, 32'hffff_ffff, 4'd0);
        add_row(ACT_LOCK, 16'h0000, 32'h0000_0000, 4'd0);
        // release to zero, release of a free entry, lock of a free entry
        add_row(ACT_RELEASE, 16'h1234, 32'h0000_0001, 4'd1);
        add_row(ACT_RELEASE, 16'h1234, 32'h0000_0001, 4'd1);
        add_row(ACT_LOCK, 16'h0000, 32'h0000_0000, 4'd1);
        add_row(ACT_GET, 16'h0000, 32'h0000_0000, 4'd0);
        // freed entry is reused and its loaded mark cleared
        add_row(ACT_GET, 16'h5555, 32'haaaa_aaaa, 4'd5);
        add_row(ACT_LOCK, 16'haaaa, 32'h5555_5555, 4'd1);
        add_row(ACT_RELEASE, 16'h0000, 32'h0000_0000, 4'd0);
        add_row(ACT_RELEASE, 16'h0000, 32'h0000_0000, 4'd0);
        add_row(ACT_RELEASE, 16'h0000, 32'h0000_0000, 4'd0);
        add_row(ACT_LOCK, 16'h0000, 32'h0000_0000, 4'd0);
        add_row(ACT_GET, 16'h0000, 32'h0000_0000, 4'd10);
        add_row(ACT_UNUSED, 16'h0000, 32'h0000_0000, 4'd0);
        add_row(ACT_RELEASE, 16'hffff, 32'hffff_ffff, 4'd0);

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n])
            drive_item(dir_rows[n].req, 0, dir_rows[n].typed, dir_rows[n].res);

        // one key hit many times in a row
        for (n = 0; n < HIT_GETS; n++)
            drive_item(make_req(ACT_GET, 16'h2bad, 32'h0000_7fff, 4'($urandom)), 0, 1'b0, none);

        // distinct keys until the table is full, then misses report full
        for (n = 0; n < ENTRIES + 2; n++)
            drive_item(make_req(ACT_GET, 16'(16'h0100 + n), 32'h8000_0000 | n, 4'($urandom)),
                       0, 1'b0, none);
        drive_item(make_req(ACT_GET, 16'h2bad, 32'h0000_7fff, 4'd0), 0, 1'b0, none);
        wait_drained();

        // random phases, sender pauses for the outstanding results between them
        for (p = 0; p < 4; p++) begin
            for (n = 0; n < PHASE_ITEMS; n++)
                drive_item(random_request(((n / MIX_SPAN) % 2) == 0), phase_pct[p], 1'b0, none);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* inode_refcount_cache.f */
rtl/irc_pkg.sv
rtl/irc_ctrl.sv
rtl/irc_datapath.sv
rtl/inode_refcount_cache.sv
dv/tb_top.sv
